[src/ctpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpc_pkg
// Shared constants and types of the compact target check: field layout of the
// compact word, error codes and the decoded target bundle.
// ----------------------------------------------------------------------------
package ctpc_pkg;

    // Digest and target geometry
    localparam int WORD_W   = 64;
    localparam int NUM_WORDS = 4;
    localparam int TARGET_W = WORD_W * NUM_WORDS;
    localparam int COEF_W   = 23;
    localparam int EXP_W    = 8;

    // Compact word layout
    localparam logic [31:0] COEF_MASK = 32'h007f_ffff;
    localparam logic [31:0] SIGN_MASK = 32'h0080_0000;
    localparam int          EXP_SHIFT = 24;
    localparam int          TARGET_BITS = 256;

    // Register map
    localparam int          ADDR_W        = 3;
    localparam logic        REG_COMPACT   = 1'b0;
    localparam logic [31:0] COMPACT_RESET = 32'h1d00_ffff;

    // Exponent bounds: at or below EXP_BASE the coefficient shifts right,
    // at or above EXP_OVER the shift reaches the full target width.
    localparam logic [EXP_W-1:0] EXP_BASE = 8'd3;
    localparam logic [EXP_W-1:0] EXP_OVER = EXP_W'(TARGET_BITS / 8 + 3);

    // Error codes, in priority order
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SIGN  = 2'd1;
    localparam logic [1:0] ERR_ZERO  = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    // Output tdata width, padded to whole bytes
    localparam int OUT_W = 8;

    typedef struct packed {
        logic [TARGET_W-1:0] value;
        logic [1:0]          err;
    } t_target;

endpackage : ctpc_pkg
`default_nettype wire

[src/ctpc_apb_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpc_apb_regs
// APB register file holding the compact target word.
// ----------------------------------------------------------------------------
module ctpc_apb_regs
    import ctpc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output logic [31:0]            o_compact
);

    logic [31:0] r_compact;
    logic [31:0] n_compact;
    logic        reg_sel;
    logic        wr_req;

    // Word index from the byte address
    assign reg_sel = (paddr[ADDR_W-1:2] == 1'(REG_COMPACT));
    assign wr_req  = psel && penable && pwrite;

    always_comb begin
        n_compact = r_compact;
        if (wr_req && reg_sel) begin
            n_compact = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compact <= COMPACT_RESET;
        end else begin
            r_compact <= n_compact;
        end
    end

    assign prdata    = reg_sel ? r_compact : 32'd0;
    assign pready    = 1'b1;
    assign o_compact = r_compact;

endmodule : ctpc_apb_regs
`default_nettype wire

[src/ctpc_target_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpc_target_decode
// Expands the compact word into a 256-bit target and its error code.
// ----------------------------------------------------------------------------
module ctpc_target_decode
    import ctpc_pkg::*;
(
    input  wire logic [31:0] i_compact,
    output t_target          o_target
);

    localparam int WIDE_W = TARGET_W + COEF_W - 8;

    logic [EXP_W-1:0]  expo;
    logic [COEF_W-1:0] coef;
    logic              sign;
    logic [EXP_W-1:0]  exp_up;
    logic [EXP_W-1:0]  exp_dn;
    logic [COEF_W-1:0] small_val;
    logic [WIDE_W-1:0] wide_val;

    assign expo = i_compact[EXP_SHIFT +: EXP_W];
    assign coef = COEF_W'(i_compact & COEF_MASK);
    assign sign = |(i_compact & SIGN_MASK);

    // Byte shift counts for both directions
    assign exp_dn = EXP_BASE - expo;
    assign exp_up = expo - EXP_BASE;

    assign small_val = coef >> {exp_dn[1:0], 3'b000};
    assign wide_val  = {{(WIDE_W-COEF_W){1'b0}}, coef} << {exp_up[4:0], 3'b000};

    always_comb begin
        o_target.value = '0;
        o_target.err   = ERR_NONE;
        if (sign) begin
            o_target.err = ERR_SIGN;
        end else if (coef == '0) begin
            o_target.err = ERR_ZERO;
        end else if (expo <= EXP_BASE) begin
            // Low bytes drop off; nothing left means a zero target
            o_target.value = {{(TARGET_W-COEF_W){1'b0}}, small_val};
            if (small_val == '0) begin
                o_target.err = ERR_RANGE;
            end
        end else if (expo >= EXP_OVER) begin
            o_target.err = ERR_RANGE;
        end else begin
            o_target.value = wide_val[TARGET_W-1:0];
            if (|wide_val[WIDE_W-1:TARGET_W]) begin
                o_target.err = ERR_RANGE;
            end
        end
        if (o_target.err != ERR_NONE) begin
            o_target.value = '0;
        end
    end

endmodule : ctpc_target_decode
`default_nettype wire

[src/ctpc_compare_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpc_compare_pipe
// Three-stage stream pipeline: capture, per-word compare, result merge.
// ----------------------------------------------------------------------------
module ctpc_compare_pipe
    import ctpc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_target             i_target,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [TARGET_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OUT_W-1:0]         m_axis_tdata
);

    logic                en1, en2, en3;
    logic                r_v1, r_v2, r_v3;
    logic [TARGET_W-1:0] r_hash;
    t_target             r_tgt;
    logic [NUM_WORDS-1:0] r_lt, r_eq;
    logic [1:0]          r_err2;
    logic                r_meets;
    logic [1:0]          r_err3;
    logic [NUM_WORDS-1:0] n_lt, n_eq;
    logic                n_le;

    // Stage advance: a stage loads when empty or when its successor moves
    assign en3 = !r_v3 || m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: capture digest and decoded target
    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid) begin
            r_hash <= s_axis_tdata;
            r_tgt  <= i_target;
        end
    end

    // Stage 2: word-wise magnitude compare
    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            n_lt[i] = r_hash[i*WORD_W +: WORD_W] < r_tgt.value[i*WORD_W +: WORD_W];
            n_eq[i] = r_hash[i*WORD_W +: WORD_W] == r_tgt.value[i*WORD_W +: WORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_lt   <= n_lt;
            r_eq   <= n_eq;
            r_err2 <= r_tgt.err;
        end
    end

    // Stage 3: most significant differing word decides
    always_comb begin
        n_le = 1'b1;
        for (int i = 0; i < NUM_WORDS; i++) begin
            n_le = r_lt[i] || (r_eq[i] && n_le);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_meets <= n_le && (r_err2 == ERR_NONE);
            r_err3  <= r_err2;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(OUT_W-3){1'b0}}, r_err3, r_meets};

endmodule : ctpc_compare_pipe
`default_nettype wire

[src/compact_target_pow_check_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compact_target_pow_check_core
// Checks 256-bit digests against a target decoded from a compact word.
// ----------------------------------------------------------------------------
// One digest per request enters on the slave stream and one result leaves on
// the master stream. The block accepts a new digest every cycle while the output
// is not stalled; each request passes through three register stages (capture,
// 64-bit word compares, merge). Backpressure on the output stalls the stages
// in place. The compact word sits in an APB register at byte address 0 (reset
// 0x1d00ffff) and is decoded combinationally; change it only while no request
// is in flight.
// ----------------------------------------------------------------------------
module compact_target_pow_check_core
    import ctpc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // APB configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // Digest stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // hash_word_0 [63:0], hash_word_1 [127:64], hash_word_2 [191:128],
    // hash_word_3 [255:192]
    input  wire logic [TARGET_W-1:0] s_axis_tdata,
    // Result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // meets_target [0], target_error [2:1], zero [7:3]
    output logic [OUT_W-1:0]         m_axis_tdata
);

    logic [31:0] compact;
    t_target     target;

    ctpc_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_compact (compact)
    );

    ctpc_target_decode u_decode (
        .i_compact (compact),
        .o_target  (target)
    );

    ctpc_compare_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_target      (target),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule : compact_target_pow_check_core
`default_nettype wire

[src/ctpc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctpc_checker
// Port-level checks of the compact target check core, bound to the top level.
// ----------------------------------------------------------------------------
module ctpc_checker
    import ctpc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                psel,
    input wire logic                penable,
    input wire logic                pwrite,
    input wire logic [ADDR_W-1:0]   paddr,
    input wire logic [31:0]         pwdata,
    input wire logic [31:0]         prdata,
    input wire logic                pready,
    input wire logic                s_axis_tvalid,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OUT_W-1:0]    m_axis_tdata
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // An error code never comes with a pass
    a_err_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:1] != ERR_NONE)) |-> !m_axis_tdata[0])
        else $error("pass reported together with a target error");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Register write is visible on the next read of the same address
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == 1'(REG_COMPACT)))
        |=> ((paddr != $past(paddr)) || (prdata == $past(pwdata))))
        else $error("compact register readback mismatch");

    // No result appears without an earlier request in flight: with the input
    // idle and the output drained long enough to empty every stage, nothing is valid
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s_axis_tvalid && !m_axis_tvalid) ##1 (!s_axis_tvalid && !m_axis_tvalid)
        ##1 (!s_axis_tvalid && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result without request");

endmodule : ctpc_checker

bind compact_target_pow_check_core ctpc_checker u_ctpc_checker (.*);
`default_nettype wire
